// ----- rtl/core/mm64_pkg.sv -----
// Package for the streaming 64-bit murmur hash unit.
// Holds the sequencer state type, the mixing constants and small helper functions.
// No dependencies.
package mm64_pkg;

    // Mixing multiplier and shift of the 64-bit murmur scheme
    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    // Halves of the multiplier, fed one at a time to the shared 32x32 unit
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_MUL,
        ST_DISPATCH,
        ST_W_MUL1,
        ST_W_MUL2,
        ST_H_MUL,
        ST_TAIL_MUL,
        ST_FIN_MUL
    } t_state;

    // Partial-product step of the shared multiplier
    typedef enum logic [1:0] {
        STEP_LO_LO,
        STEP_HI_LO,
        STEP_LO_HI
    } t_step;

    // Keep the low bytes of a tail word, 1 to 7 bytes
    function automatic logic [63:0] tail_mask(input logic [2:0] bytes);
        logic [63:0] mask;
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (3'(b) < bytes) begin
                mask[b*8 +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

    // Fold the top bits down: x ^ (x >> 47)
    function automatic logic [63:0] fold_shift(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

// ----- rtl/core/murmur64a_stream_hash_unit.sv -----
// Streaming 64-bit murmur hash unit, top level.
// Depends on mm64_pkg (state type, mixing constants, helper functions).
//
// Takes a message as little-endian 64-bit words and returns one 64-bit hash
// per message, on the transaction that carries the last word. The first word
// also carries the total byte length, which is mixed with the seed register.
// All multiplications mod 2^64 by the mixing constant go through one shared
// 32x32 multiplier, partial product by partial product. An input transaction
// is accepted only while the sequencer is idle. A full word is dispatched and
// multiplied three times, after a length multiplication if first and before
// a final avalanche if last. A tail word of 1 to 7 bytes gets a multiply and
// the avalanche, an empty last word just the avalanche; a short word before
// the last sets the error flag. The result sits in an output register; the
// final multiplication holds only while that register is full and stalled.
// Write the seed only while no message is in progress.
module murmur64a_stream_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_word_bytes,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_message_length,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value,
    output logic        o_framing_error
);
    import mm64_pkg::*;

    // Control and hash state
    t_state      r_state, n_state;
    t_step       r_step, n_step;
    logic [63:0] r_seed;
    logic [63:0] r_hash, n_hash;
    logic        r_err, n_err;
    logic [63:0] r_op, n_op;
    logic [63:0] r_acc, n_acc;

    // Captured transaction
    logic [63:0] r_word;
    logic        r_full;
    logic [2:0]  r_bytes;
    logic        r_last;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_hash, n_out_hash;
    logic        r_out_err, n_out_err;

    // Shared multiplier
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_pp;
    logic [63:0] w_mul_res;
    logic        w_in_mul;
    logic        w_mul_done;
    logic        w_accept;
    logic        w_out_free;

    // Pick the operand halves for this partial product
    always_comb begin
        w_mul_a = (r_step == STEP_HI_LO) ? r_op[63:32] : r_op[31:0];
        w_mul_b = (r_step == STEP_LO_HI) ? MIX_MUL_HI : MIX_MUL_LO;
    end

    assign w_pp = w_mul_a * w_mul_b;

    // Accumulate the low 64 bits of op * MIX_MUL
    assign w_mul_res = (r_step == STEP_LO_LO) ? w_pp : r_acc + {w_pp[31:0], 32'h0};

    assign w_in_mul   = (r_state == ST_LEN_MUL) || (r_state == ST_W_MUL1) ||
                        (r_state == ST_W_MUL2) || (r_state == ST_H_MUL) ||
                        (r_state == ST_TAIL_MUL) || (r_state == ST_FIN_MUL);
    assign w_mul_done = (r_step == STEP_LO_HI);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_hash      = r_hash;
        n_err       = r_err;
        n_op        = r_op;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hash  = r_out_hash;
        n_out_err   = r_out_err;

        // Advance the multiplier through its partial products
        if (w_in_mul && !w_mul_done) begin
            n_step = (r_step == STEP_LO_LO) ? STEP_HI_LO : STEP_LO_HI;
            n_acc  = w_mul_res;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op    = {32'h0, i_message_length};
                    n_step  = STEP_LO_LO;
                    n_state = i_first_word ? ST_LEN_MUL : ST_DISPATCH;
                end
            end
            ST_LEN_MUL: begin
                if (w_mul_done) begin
                    n_hash  = r_seed ^ w_mul_res;
                    n_err   = 1'b0;
                    n_step  = STEP_LO_LO;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (r_full) begin
                    n_op    = r_word;
                    n_state = ST_W_MUL1;
                end else if (!r_last) begin
                    n_err   = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_bytes != 3'd0) begin
                    n_op    = r_hash ^ (r_word & tail_mask(r_bytes));
                    n_state = ST_TAIL_MUL;
                end else begin
                    n_op    = fold_shift(r_hash);
                    n_state = ST_FIN_MUL;
                end
            end
            ST_W_MUL1: begin
                if (w_mul_done) begin
                    n_op    = fold_shift(w_mul_res);
                    n_step  = STEP_LO_LO;
                    n_state = ST_W_MUL2;
                end
            end
            ST_W_MUL2: begin
                if (w_mul_done) begin
                    n_op    = r_hash ^ w_mul_res;
                    n_step  = STEP_LO_LO;
                    n_state = ST_H_MUL;
                end
            end
            ST_H_MUL: begin
                if (w_mul_done) begin
                    n_hash  = w_mul_res;
                    n_op    = fold_shift(w_mul_res);
                    n_step  = STEP_LO_LO;
                    n_state = r_last ? ST_FIN_MUL : ST_IDLE;
                end
            end
            ST_TAIL_MUL: begin
                if (w_mul_done) begin
                    n_hash  = w_mul_res;
                    n_op    = fold_shift(w_mul_res);
                    n_step  = STEP_LO_LO;
                    n_state = ST_FIN_MUL;
                end
            end
            ST_FIN_MUL: begin
                // Hold on the last partial product until the output register frees
                if (w_mul_done && w_out_free) begin
                    n_out_hash  = fold_shift(w_mul_res);
                    n_out_err   = r_err;
                    n_out_valid = 1'b1;
                    n_err       = 1'b0;
                    n_step      = STEP_LO_LO;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Port outputs
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        o_out_valid     = r_out_valid;
        o_hash_value    = r_out_hash;
        o_framing_error = r_out_err;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_LO_LO;
            r_seed      <= '0;
            r_hash      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_hash      <= n_hash;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_acc      <= n_acc;
        r_out_hash <= n_out_hash;
        r_out_err  <= n_out_err;
        if (w_accept) begin
            r_word  <= i_data_word;
            r_full  <= i_word_bytes[3];
            r_bytes <= i_word_bytes[2:0];
            r_last  <= i_last_word;
        end
    end

endmodule

// ----- rtl/core/mm64_checker.sv -----
// Port-level checker for the streaming 64-bit murmur hash unit.
// Depends on murmur64a_stream_hash_unit; attached to it by the bind below.
module mm64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_hash_value,
    input logic        o_framing_error
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled result payload stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_hash_value) && $stable(o_framing_error)))
        else $error("result payload changed while stalled");

    // Go busy right after taking an input transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without processing");

    // Produce a new result only out of a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a message in progress");

endmodule

bind murmur64a_stream_hash_unit mm64_checker u_mm64_checker (.*);

// ----- tb/murmur64a_stream_hash_unit_tb.sv -----
// Testbench for the streaming MurmurHash64A unit: directed and random messages
// checked against a built-in bit-accurate hash predictor, with random backpressure.
// Depends only on the RTL top level murmur64a_stream_hash_unit.
`timescale 1ns / 1ps

module murmur64a_stream_hash_unit_tb;

    localparam logic [63:0] MURMUR_M        = 64'hc6a4a7935bd1e995;
    localparam int          MURMUR_R        = 47;
    localparam int          FULL_WORD_BYTES = 8;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          RANDOM_ITEMS    = 1250;
    localparam int          PHASE_ITEMS     = 250;

    typedef struct {
        logic [63:0] hash;
        logic        err;
    } t_digest;

    // Clock, reset and block ports
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [63:0] cfg_data       = '0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [63:0] data_word      = '0;
    logic [3:0]  word_bytes     = '0;
    logic        first_word     = 1'b0;
    logic        last_word      = 1'b0;
    logic [31:0] message_length = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [63:0] hash_value;
    logic        framing_error;

    // Predictor state and expected digests
    logic [63:0] seed_reg    = '0;
    logic [63:0] run_hash    = '0;
    logic        err_flag    = 1'b0;
    t_digest     expected_digests[$];

    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned rx_hold_cycles = 0;
    bit          idle_on        = 1'b0;

    murmur64a_stream_hash_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_word      (data_word),
        .i_word_bytes     (word_bytes),
        .i_first_word     (first_word),
        .i_last_word      (last_word),
        .i_message_length (message_length),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_hash_value     (hash_value),
        .o_framing_error  (framing_error)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the running hash by one accepted word; queue a digest on the last one
    function automatic void absorb_word(input logic [63:0] word, input logic [3:0] nbytes,
                                        input logic first, input logic last,
                                        input logic [31:0] len);
        logic [63:0] k;
        logic [63:0] h;
        int          n;
        t_digest     d;
        n = (nbytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES : int'(nbytes);
        if (first) begin
            run_hash = seed_reg ^ ({32'b0, len} * MURMUR_M);
            err_flag = 1'b0;
        end
        if (n == FULL_WORD_BYTES) begin
            k = word * MURMUR_M;
            k = k ^ (k >> MURMUR_R);
            k = k * MURMUR_M;
            run_hash = (run_hash ^ k) * MURMUR_M;
        end else if (!last) begin
            err_flag = 1'b1;
        end else if (n != 0) begin
            run_hash = (run_hash ^ (word & ((64'd1 << (8 * n)) - 64'd1))) * MURMUR_M;
        end
        if (last) begin
            h = run_hash;
            h = h ^ (h >> MURMUR_R);
            h = h * MURMUR_M;
            h = h ^ (h >> MURMUR_R);
            d.hash = h;
            d.err  = err_flag;
            expected_digests.push_back(d);
            err_flag = 1'b0;
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] random_word();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '1;
        if (pick == 1) return '0;
        if (pick == 2) return 64'd1 << $urandom_range(0, 63);
        return {$urandom, $urandom};
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_word(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic first, input logic last, input logic [31:0] len);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 35) gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        data_word      = word;
        word_bytes     = nbytes;
        first_word     = first;
        last_word      = last;
        message_length = len;
        in_valid       = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        absorb_word(word, nbytes, first, last, len);
        words_sent++;
    endtask

    // Drop valid, wait for every digest, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_digests.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        seed_reg = value;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // One message of random words, sometimes with broken framing
    task automatic send_random_message();
        int          nwords;
        int          tail;
        int          k;
        int unsigned style;
        logic [31:0] len;
        logic [3:0]  nb;
        logic        first;
        logic        last;
        style  = $urandom_range(0, 99);
        nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        tail   = $urandom_range(0, FULL_WORD_BYTES);
        len    = 32'(FULL_WORD_BYTES * (nwords - 1) + tail);
        if ($urandom_range(0, 9) == 0) len = $urandom;
        for (k = 0; k < nwords; k++) begin
            first = (k == 0);
            last  = (k == nwords - 1);
            nb    = last ? 4'(tail) : 4'(FULL_WORD_BYTES);
            if ($urandom_range(0, 15) == 0) nb = 4'($urandom_range(9, 15));
            if (style >= 85) begin
                if (!last && $urandom_range(0, 3) == 0) nb = 4'($urandom_range(0, 7));
                if (k == 0 && $urandom_range(0, 2) == 0) first = 1'b0;
                if (k > 0 && $urandom_range(0, 5) == 0) first = 1'b1;
            end
            send_word(random_word(), nb, first, last, first ? len : $urandom);
        end
    endtask

    // Reset seed: flags, byte counts, tails and framing corner cases
    task automatic test_directed_words();
        int n;
        idle_on = 1'b0;
        // no first item after reset: continue from the cleared hash
        send_word(64'h0123456789abcdef, 4'd8, 1'b0, 1'b0, 32'd0);
        send_word('1, 4'd3, 1'b0, 1'b1, 32'd0);
        send_word('0, 4'd0, 1'b1, 1'b1, 32'd0);
        send_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
        send_word('0, 4'd8, 1'b1, 1'b1, 32'hffffffff);
        for (n = 1; n < FULL_WORD_BYTES; n++) begin
            send_word('1, 4'(n), 1'b1, 1'b1, 32'(n));
        end
        // counts above eight act as a full word
        send_word(64'haaaa5555aaaa5555, 4'd9, 1'b1, 1'b1, 32'd8);
        send_word(64'h5555aaaa5555aaaa, 4'd15, 1'b1, 1'b1, 32'd8);
        // short words before the last raise the error flag
        send_word(64'hfedcba9876543210, 4'd5, 1'b1, 1'b0, 32'd13);
        send_word(64'h0f0f0f0f0f0f0f0f, 4'd0, 1'b0, 1'b0, 32'hffffffff);
        send_word(64'hf0f0f0f0f0f0f0f0, 4'd8, 1'b0, 1'b1, 32'd0);
        // a new first item in mid-message restarts the hash
        send_word(64'h1111111111111111, 4'd8, 1'b1, 1'b0, 32'd24);
        send_word(64'h2222222222222222, 4'd8, 1'b1, 1'b0, 32'd10);
        send_word(64'h3333333333333333, 4'd2, 1'b0, 1'b1, 32'd0);
        // last item with no first after a finished message
        send_word(64'h8000000000000001, 4'd4, 1'b0, 1'b1, 32'd0);
        wait_idle();
    endtask

    // Seed extremes and a random seed, each with an empty and a two-word message
    task automatic test_seed_settings();
        logic [63:0] seeds[4];
        int          s;
        seeds[0] = '1;
        seeds[1] = 64'h8000000000000001;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = '0;
        idle_on  = 1'b1;
        for (s = 0; s < 4; s++) begin
            write_seed(seeds[s]);
            send_word(random_word(), 4'd0, 1'b1, 1'b1, 32'd0);
            send_word(random_word(), 4'd8, 1'b1, 1'b0, 32'd14);
            send_word(random_word(), 4'd6, 1'b0, 1'b1, $urandom);
            wait_idle();
        end
    endtask

    // Hold the output long enough that the block fills and stalls its input
    task automatic test_output_backpressure();
        int m;
        idle_on        = 1'b0;
        rx_hold_cycles = 400;
        for (m = 0; m < 8; m++) begin
            if (m % 3 == 2) send_word(random_word(), 4'd8, 1'b1, 1'b0, 32'd11);
            send_word(random_word(), 4'($urandom_range(0, 8)), m % 3 != 2, 1'b1, 32'd8);
        end
        wait_idle();
    endtask

    // Random messages in phases, with a new seed between phases
    task automatic test_random_messages();
        int unsigned start;
        int unsigned phase_start;
        int          phase;
        start = words_sent;
        phase = 0;
        while (words_sent - start < RANDOM_ITEMS) begin
            case (phase % 4)
                0: write_seed({$urandom, $urandom});
                1: write_seed('1);
                2: write_seed('0);
                default: write_seed(64'd1 << $urandom_range(0, 63));
            endcase
            idle_on     = (phase % 3 != 1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_ITEMS) begin
                // stray words outside any message
                if ($urandom_range(0, 19) == 0) begin
                    send_word(random_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, $urandom);
                end
                send_random_message();
            end
            wait_idle();
            phase++;
        end
    endtask

    // Receiver: random stall runs, or a long counted hold when requested
    initial begin
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                out_stall = 1'b1;
                while (rx_hold_cycles > 0) begin
                    @(negedge clk);
                    rx_hold_cycles--;
                end
                out_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                out_stall = 1'b1;
                repeat (pick_gap()) @(negedge clk);
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expected digest
    always @(posedge clk) begin
        t_digest d;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_digests.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result hash %h err %b",
                         $time, hash_value, framing_error);
            end else begin
                d = expected_digests.pop_front();
                if (hash_value !== d.hash) begin
                    mismatch_count++;
                    $display("%0t: hash_value expected %h actual %h",
                             $time, d.hash, hash_value);
                end
                if (framing_error !== d.err) begin
                    mismatch_count++;
                    $display("%0t: framing_error expected %b actual %b",
                             $time, d.err, framing_error);
                end
            end
        end
    end

    // Test sequence
    initial begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_words();
        test_seed_settings();
        test_output_backpressure();
        test_random_messages();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
